@@ rtl/core/rwa_pkg.sv @@
// Shared types and constants for the running window average core.
// Used by the top level and the divider; no dependencies of its own.
// Holds field widths, register defaults, the control state type and divider status.
package rwa_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 7;
    localparam int DEFAULT_DEPTH  = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Largest magnitudes of a signed 16-bit average.
    localparam int AVG_POS_LIMIT  = 32767;
    localparam int AVG_NEG_LIMIT  = 32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_OUT
    } rwa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rwa_div_status_t;

endpackage

@@ rtl/core/running_window_average_core.sv @@
// Top level of the running window average core.
// Depends on rwa_pkg, rwa_ram (sample ring) and rwa_div (rounding divider).

// The core takes one signed 16-bit sample per input word, stores it in a ring of
// window_length entries held in a RAM, keeps a running sum by removing the entry it
// overwrites, and returns one output word per sample: the mean of the stored samples,
// rounded half away from zero and saturated to the 16-bit range. Until the ring has
// wrapped once the divisor is the number of samples taken; after that it is the window
// length. A window_length of 0 acts as 1 and a value above WINDOW_DEPTH acts as
// WINDOW_DEPTH; changing it does not clear the ring, the sum or the write position.
// The ring reads as all zeros after reset through one valid bit per entry, so there is
// no clearing pass. One sample is processed at a time: from acceptance, the old entry is
// read, then sum and ring are updated, then the divide is set up, then the restoring
// divider produces one quotient bit per cycle and flags done, and then the output register
// is loaded. A new word is accepted only once the previous one has been loaded into the
// output register. The input is accepted again while a finished output word
// still waits for m_axis_tready. Configuration writes are always ready and must only
// be issued while the core is idle.
module running_window_average_core #(
    parameter int WINDOW_DEPTH = rwa_pkg::DEFAULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write channel: window_length.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rwa_pkg::CFG_W-1:0]    cfg_data,
    // Input stream. tdata bits [15:0]: sample.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rwa_pkg::SAMPLE_W-1:0] s_axis_tdata,
    // Output stream. tdata bits [15:0]: average.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rwa_pkg::SAMPLE_W-1:0] m_axis_tdata
);

    import rwa_pkg::*;

    // Ring address width, width to hold a length up to the depth, and sum width.
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + ADDR_W;
    // Divider operands: 2*|sum| + den over 2*den.
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = LEN_W + 1;

    rwa_state_t                  state_reg;
    rwa_state_t                  state_next;
    logic [CFG_W-1:0]            length_reg;
    logic [ADDR_W-1:0]           pos_reg;
    logic [ADDR_W-1:0]           pos_next;
    logic                        filled_reg;
    logic                        filled_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic [LEN_W-1:0]            den_reg;
    logic [LEN_W-1:0]            den_next;
    logic [ADDR_W-1:0]           idx_reg;
    logic [ADDR_W-1:0]           idx_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic signed [SAMPLE_W-1:0]  sample_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [SAMPLE_W-1:0]         avg_reg;
    logic [SAMPLE_W-1:0]         avg_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [SAMPLE_W-1:0]         out_data_reg;
    logic [SAMPLE_W-1:0]         out_data_next;
    logic [WINDOW_DEPTH-1:0]     entry_valid_reg;

    logic [LEN_W-1:0]            len_use;
    logic [ADDR_W-1:0]           idx_sel;
    logic [LEN_W-1:0]            idx_inc;
    logic signed [SAMPLE_W-1:0]  old_sample;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic                        ram_we;
    logic                        ram_re;
    logic                        div_start;
    logic [SUM_W-1:0]            sum_mag;
    logic [NUM_W-1:0]            dividend;
    logic [DEN_W-1:0]            divisor;
    logic [NUM_W-1:0]            quotient;
    rwa_div_status_t             div_status;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Clamp the programmed length into 1..WINDOW_DEPTH.
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_use = LEN_W'(1);
        end
        else if (9'(length_reg) > 9'(WINDOW_DEPTH))
        begin
            len_use = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_use = LEN_W'(length_reg);
        end
    end

    // A write position left beyond a shrunken window falls back to entry zero.
    assign idx_sel    = (LEN_W'(pos_reg) < len_use) ? pos_reg : '0;
    assign idx_inc    = LEN_W'(idx_reg) + LEN_W'(1);
    assign old_sample = entry_valid_reg[idx_reg] ? $signed(ram_rdata) : '0;
    assign ram_re     = s_axis_tvalid && (state_reg == ST_IDLE);

    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dividend = {sum_mag, 1'b0} + NUM_W'(den_reg);
    assign divisor  = {den_reg, 1'b0};

    rwa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_reg),
        .wdata(sample_reg),
        .re   (ram_re),
        .raddr(idx_sel),
        .rdata(ram_rdata)
    );

    rwa_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(dividend),
        .divisor (divisor),
        .quotient(quotient),
        .status  (div_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        sum_next       = sum_reg;
        den_next       = den_reg;
        idx_next       = idx_reg;
        sample_next    = sample_reg;
        neg_next       = neg_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // The old entry is read from the ring in the same cycle.
                if (s_axis_tvalid)
                begin
                    sample_next = $signed(s_axis_tdata);
                    idx_next    = idx_sel;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // Swap the old entry for the new sample in the ring and in the sum.
                sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                ram_we   = 1'b1;
                if (idx_inc >= len_use)
                begin
                    pos_next    = '0;
                    filled_next = 1'b1;
                    den_next    = len_use;
                end
                else
                begin
                    pos_next = ADDR_W'(idx_inc);
                    den_next = filled_reg ? len_use : idx_inc;
                end
                state_next = ST_START;
            end
            ST_START:
            begin
                neg_next   = sum_reg[SUM_W-1];
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Restore the sign and saturate to the 16-bit range.
                if (div_status.done)
                begin
                    if (!neg_reg)
                    begin
                        avg_next = (quotient > NUM_W'(AVG_POS_LIMIT)) ?
                                   SAMPLE_W'(AVG_POS_LIMIT) : quotient[SAMPLE_W-1:0];
                    end
                    else if (quotient > NUM_W'(AVG_NEG_LIMIT))
                    begin
                        avg_next = SAMPLE_W'(AVG_NEG_LIMIT);
                    end
                    else
                    begin
                        avg_next = ~quotient[SAMPLE_W-1:0] + SAMPLE_W'(1);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = avg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            length_reg      <= CFG_RESET;
            pos_reg         <= '0;
            filled_reg      <= 1'b0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                length_reg <= cfg_data;
            end
            if (ram_we)
            begin
                entry_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg      <= den_next;
        idx_reg      <= idx_next;
        sample_reg   <= sample_next;
        neg_reg      <= neg_next;
        avg_reg      <= avg_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // Every accepted word starts the ring read-modify-write.
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_READ))
        else $error("accepted word did not start a ring update");

    // A new output word only appears from the output load state.
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("output word appeared outside the output load");

    // The divisor handed to the divider is never zero.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |-> (den_reg != '0))
        else $error("zero divisor at divider start");

    // The divider only finishes while the control waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

@@ rtl/core/rwa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependency; width and depth come from parameters.
module rwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rwa_div.sv @@
// Iterative restoring divider, one quotient bit per clock cycle.
// Depends on rwa_pkg for the status struct.
module rwa_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_W-1:0]         dividend,
    input  logic [DEN_W-1:0]         divisor,
    output logic [NUM_W-1:0]         quotient,
    output rwa_pkg::rwa_div_status_t status
);

    import rwa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] acc_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // Bring down the next dividend bit and try a subtraction.
    always_comb
    begin
        rem_shift = {rem_reg, acc_reg[NUM_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        ge        = ~diff[DEN_W+1];
        rem_next  = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        acc_next  = {acc_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
